@@ sv/octilinear_polyline_plotter_defines.svh @@
// Assertion macros shared by the octilinear polyline plotter RTL.
`ifndef OCTILINEAR_POLYLINE_PLOTTER_DEFINES_SVH
`define OCTILINEAR_POLYLINE_PLOTTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OPP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OPP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/opp_pkg.sv @@
// Package with constants, codes and helper functions of the polyline plotter.
`timescale 1ns / 1ps

package opp_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int CFG_W   = 7;
    localparam int COORD_W = 6;
    localparam int CNT_W   = 16;
    localparam int ROW_W   = 64;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int ROW_AW  = $clog2(MAX_ROWS);
    localparam int CFG_MAX = (1 << CFG_W) - 1;
    localparam int DIM_MAX = (MAX_ROWS > CFG_MAX) ? MAX_ROWS : CFG_MAX;
    localparam int DIM_W   = $clog2(DIM_MAX + 1);

    localparam logic [1:0] OP_MOVE = 2'd0;
    localparam logic [1:0] OP_DRAW = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NOT_OCT = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic REG_GRID_ROWS = 1'b0;
    localparam logic REG_GRID_COLS = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX         = '1;
    localparam logic [CNT_W-1:0] POINT_FIRST     = CNT_W'(1);
    localparam logic [CNT_W-1:0] POINT_FIRST_SEG = CNT_W'(2);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] g,
                                                    input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        r = DIM_W'(g);
        if (r == '0)
        begin
            r = DIM_W'(1);
        end
        else if (r > lim)
        begin
            r = lim;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] rows_used(input logic [CFG_W-1:0] g);
        return clamp_dim(g, DIM_W'(MAX_ROWS));
    endfunction

    function automatic logic [DIM_W-1:0] cols_used(input logic [CFG_W-1:0] g);
        return clamp_dim(g, DIM_W'(MAX_COLS));
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
    endfunction

endpackage

@@ sv/octilinear_polyline_plotter.sv @@
// Octilinear polyline plotter: control sequencer, row walker and bitmap memory.
// A move, an error answer or an unused op goes from acceptance to the result registers, then to the output registers.
// A read passes through the memory read (one memory read, registered), the result registers and the output registers.
// A draw walks one bitmap row per cycle through a read-modify-write pipeline on the
// single memory port pair, then flushes the last row before its result is handed on.
// One transaction is in work at a time; the next is taken once its result is handed on.
// Reset is asynchronous and clears the bitmap at once through per-row valid bits.
`timescale 1ns / 1ps
`include "octilinear_polyline_plotter_defines.svh"

module octilinear_polyline_plotter
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [opp_pkg::PADDR_W-1:0]       paddr,
    input  logic [opp_pkg::PDATA_W-1:0]       pwdata,
    output logic [opp_pkg::PDATA_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [opp_pkg::COORD_W-1:0]       coord_x,
    input  logic [opp_pkg::COORD_W-1:0]       coord_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        status,
    output logic [opp_pkg::CNT_W-1:0]         polyline_number,
    output logic [opp_pkg::CNT_W-1:0]         point_number,
    output logic [opp_pkg::ROW_W-1:0]         row_bits
);

    typedef enum logic [4:0]
    {
        ST_IDLE   = 5'b00001,
        ST_WALK   = 5'b00010,
        ST_FLUSH  = 5'b00100,
        ST_RDWAIT = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    localparam int CW = opp_pkg::COORD_W;
    localparam int NW = opp_pkg::CNT_W;
    localparam int AW = opp_pkg::ROW_AW;
    localparam int MC = opp_pkg::MAX_COLS;
    localparam int DW = opp_pkg::DIM_W;

    state_t                      state_reg, state_next;
    logic [opp_pkg::CFG_W-1:0]   grid_rows_reg, grid_rows_next;
    logic [opp_pkg::CFG_W-1:0]   grid_cols_reg, grid_cols_next;
    logic [CW-1:0]               pen_x_reg, pen_x_next;
    logic [CW-1:0]               pen_y_reg, pen_y_next;
    logic [NW-1:0]               poly_cnt_reg, poly_cnt_next;
    logic [NW-1:0]               point_cnt_reg, point_cnt_next;
    logic                        err_reg, err_next;
    logic [CW-1:0]               cur_x_reg, cur_x_next;
    logic [CW-1:0]               cur_y_reg, cur_y_next;
    logic                        x_up_reg, x_up_next;
    logic                        x_dn_reg, x_dn_next;
    logic                        y_up_reg, y_up_next;
    logic                        y_dn_reg, y_dn_next;
    logic [CW-1:0]               remain_reg, remain_next;
    logic                        horiz_reg, horiz_next;
    logic [CW-1:0]               xlo_reg, xlo_next;
    logic [CW-1:0]               xhi_reg, xhi_next;
    logic                        pipe_valid_reg, pipe_valid_next;
    logic [AW-1:0]               pipe_addr_reg, pipe_addr_next;
    logic [MC-1:0]               pipe_mask_reg, pipe_mask_next;
    logic [1:0]                  res_status_reg, res_status_next;
    logic [NW-1:0]               res_poly_reg, res_poly_next;
    logic [NW-1:0]               res_point_reg, res_point_next;
    logic [opp_pkg::ROW_W-1:0]   res_row_reg, res_row_next;
    logic                        out_valid_reg, out_valid_next;
    logic [1:0]                  out_status_reg, out_status_next;
    logic [NW-1:0]               out_poly_reg, out_poly_next;
    logic [NW-1:0]               out_point_reg, out_point_next;
    logic [opp_pkg::ROW_W-1:0]   out_row_reg, out_row_next;
    logic [opp_pkg::MAX_ROWS-1:0] row_valid_reg, row_valid_next;
    logic                        rd_valid_reg, rd_valid_next;
    logic [MC-1:0]               rd_data_reg;

    logic [MC-1:0]               bitmap_mem [opp_pkg::MAX_ROWS];

    logic [AW-1:0]               rd_addr;
    logic [MC-1:0]               wr_data;
    logic [MC-1:0]               old_row;
    logic [MC-1:0]               walk_mask;
    logic [MC-1:0]               col_mask;
    logic [CW-1:0]               mask_lo;
    logic [CW-1:0]               mask_hi;
    logic [DW-1:0]               rows_u;
    logic [DW-1:0]               cols_u;
    logic                        tgt_in;
    logic                        pen_in;
    logic                        y_in;
    logic [CW-1:0]               adx;
    logic [CW-1:0]               ady;
    logic                        octi;
    logic                        cfg_wr;
    logic                        out_free;
    logic                        accept;

    assign pready    = 1'b1;
    assign cfg_wr    = psel & penable & pwrite;
    assign prdata    = (paddr[2] == opp_pkg::REG_GRID_COLS) ?
                       opp_pkg::PDATA_W'(grid_cols_reg) : opp_pkg::PDATA_W'(grid_rows_reg);

    assign in_ready        = (state_reg == ST_IDLE);
    assign accept          = in_valid & in_ready;
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign polyline_number = out_poly_reg;
    assign point_number    = out_point_reg;
    assign row_bits        = out_row_reg;
    assign out_free        = !out_valid_reg || out_ready;

    assign rows_u = opp_pkg::rows_used(grid_rows_reg);
    assign cols_u = opp_pkg::cols_used(grid_cols_reg);
    assign y_in   = DW'(coord_y) < rows_u;
    assign tgt_in = (DW'(coord_x) < cols_u) && y_in;
    assign pen_in = (DW'(pen_x_reg) < cols_u) && (DW'(pen_y_reg) < rows_u);
    assign adx    = (coord_x >= pen_x_reg) ? coord_x - pen_x_reg : pen_x_reg - coord_x;
    assign ady    = (coord_y >= pen_y_reg) ? coord_y - pen_y_reg : pen_y_reg - coord_y;
    assign octi   = (adx == '0) || (ady == '0) || (adx == ady);

    assign rd_addr = (state_reg == ST_WALK) ? AW'(cur_y_reg) : AW'(coord_y);
    assign old_row = rd_valid_reg ? rd_data_reg : '0;
    assign wr_data = old_row | pipe_mask_reg;
    assign mask_lo = horiz_reg ? xlo_reg : cur_x_reg;
    assign mask_hi = horiz_reg ? xhi_reg : cur_x_reg;

    always_comb
    begin
        for (int i = 0; i < MC; i++)
        begin
            walk_mask[i] = (CW'(i) >= mask_lo) && (CW'(i) <= mask_hi);
            col_mask[i]  = DW'(i) < cols_u;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        grid_rows_next  = grid_rows_reg;
        grid_cols_next  = grid_cols_reg;
        pen_x_next      = pen_x_reg;
        pen_y_next      = pen_y_reg;
        poly_cnt_next   = poly_cnt_reg;
        point_cnt_next  = point_cnt_reg;
        err_next        = err_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        x_up_next       = x_up_reg;
        x_dn_next       = x_dn_reg;
        y_up_next       = y_up_reg;
        y_dn_next       = y_dn_reg;
        remain_next     = remain_reg;
        horiz_next      = horiz_reg;
        xlo_next        = xlo_reg;
        xhi_next        = xhi_reg;
        pipe_valid_next = 1'b0;
        pipe_addr_next  = pipe_addr_reg;
        pipe_mask_next  = pipe_mask_reg;
        res_status_next = res_status_reg;
        res_poly_next   = res_poly_reg;
        res_point_next  = res_point_reg;
        res_row_next    = res_row_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_poly_next   = out_poly_reg;
        out_point_next  = out_point_reg;
        out_row_next    = out_row_reg;
        row_valid_next  = row_valid_reg;
        rd_valid_next   = row_valid_reg[rd_addr];

        if (cfg_wr)
        begin
            if (paddr[2] == opp_pkg::REG_GRID_COLS)
            begin
                grid_cols_next = pwdata[opp_pkg::CFG_W-1:0];
            end
            else
            begin
                grid_rows_next = pwdata[opp_pkg::CFG_W-1:0];
            end
        end

        if (pipe_valid_reg)
        begin
            row_valid_next[pipe_addr_reg] = 1'b1;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_poly_next  = poly_cnt_reg;
                    res_point_next = point_cnt_reg;
                    res_row_next   = '0;
                    res_status_next = err_reg ? opp_pkg::STATUS_NOT_OCT : opp_pkg::STATUS_OK;
                    state_next     = ST_RESP;
                    unique case (op)
                        opp_pkg::OP_READ:
                        begin
                            if (!y_in)
                            begin
                                res_status_next = opp_pkg::STATUS_OUTSIDE;
                            end
                            else
                            begin
                                state_next = ST_RDWAIT;
                            end
                        end
                        opp_pkg::OP_MOVE:
                        begin
                            if (err_reg)
                            begin
                                res_status_next = opp_pkg::STATUS_NOT_OCT;
                            end
                            else if (!tgt_in)
                            begin
                                res_status_next = opp_pkg::STATUS_OUTSIDE;
                            end
                            else
                            begin
                                poly_cnt_next  = opp_pkg::sat_inc(poly_cnt_reg);
                                point_cnt_next = opp_pkg::POINT_FIRST_SEG;
                                pen_x_next     = coord_x;
                                pen_y_next     = coord_y;
                                res_poly_next  = opp_pkg::sat_inc(poly_cnt_reg);
                                res_point_next = opp_pkg::POINT_FIRST;
                            end
                        end
                        opp_pkg::OP_DRAW:
                        begin
                            if (err_reg)
                            begin
                                res_status_next = opp_pkg::STATUS_NOT_OCT;
                            end
                            else if (!tgt_in || !pen_in)
                            begin
                                res_status_next = opp_pkg::STATUS_OUTSIDE;
                            end
                            else if (!octi)
                            begin
                                err_next        = 1'b1;
                                res_status_next = opp_pkg::STATUS_NOT_OCT;
                            end
                            else
                            begin
                                cur_x_next     = pen_x_reg;
                                cur_y_next     = pen_y_reg;
                                x_up_next      = coord_x > pen_x_reg;
                                x_dn_next      = coord_x < pen_x_reg;
                                y_up_next      = coord_y > pen_y_reg;
                                y_dn_next      = coord_y < pen_y_reg;
                                horiz_next     = (ady == '0);
                                remain_next    = ady;
                                xlo_next       = (coord_x < pen_x_reg) ? coord_x : pen_x_reg;
                                xhi_next       = (coord_x < pen_x_reg) ? pen_x_reg : coord_x;
                                pen_x_next     = coord_x;
                                pen_y_next     = coord_y;
                                point_cnt_next = opp_pkg::sat_inc(point_cnt_reg);
                                state_next     = ST_WALK;
                            end
                        end
                        default:
                        begin
                            res_row_next = '0;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                pipe_valid_next = 1'b1;
                pipe_addr_next  = AW'(cur_y_reg);
                pipe_mask_next  = walk_mask;
                if (remain_reg == '0)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    remain_next = remain_reg - CW'(1);
                    if (x_up_reg)
                    begin
                        cur_x_next = cur_x_reg + CW'(1);
                    end
                    else if (x_dn_reg)
                    begin
                        cur_x_next = cur_x_reg - CW'(1);
                    end
                    if (y_up_reg)
                    begin
                        cur_y_next = cur_y_reg + CW'(1);
                    end
                    else if (y_dn_reg)
                    begin
                        cur_y_next = cur_y_reg - CW'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_RESP;
            end
            ST_RDWAIT:
            begin
                res_row_next = opp_pkg::ROW_W'(old_row & col_mask);
                state_next   = ST_RESP;
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_poly_next   = res_poly_reg;
                    out_point_next  = res_point_reg;
                    out_row_next    = res_row_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            grid_rows_reg  <= opp_pkg::CFG_W'(opp_pkg::MAX_ROWS);
            grid_cols_reg  <= opp_pkg::CFG_W'(opp_pkg::MAX_COLS);
            pen_x_reg      <= '0;
            pen_y_reg      <= '0;
            poly_cnt_reg   <= '0;
            point_cnt_reg  <= opp_pkg::POINT_FIRST_SEG;
            err_reg        <= 1'b0;
            remain_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_valid_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            grid_rows_reg  <= grid_rows_next;
            grid_cols_reg  <= grid_cols_next;
            pen_x_reg      <= pen_x_next;
            pen_y_reg      <= pen_y_next;
            poly_cnt_reg   <= poly_cnt_next;
            point_cnt_reg  <= point_cnt_next;
            err_reg        <= err_next;
            remain_reg     <= remain_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
            row_valid_reg  <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        x_up_reg       <= x_up_next;
        x_dn_reg       <= x_dn_next;
        y_up_reg       <= y_up_next;
        y_dn_reg       <= y_dn_next;
        horiz_reg      <= horiz_next;
        xlo_reg        <= xlo_next;
        xhi_reg        <= xhi_next;
        pipe_addr_reg  <= pipe_addr_next;
        pipe_mask_reg  <= pipe_mask_next;
        res_status_reg <= res_status_next;
        res_poly_reg   <= res_poly_next;
        res_point_reg  <= res_point_next;
        res_row_reg    <= res_row_next;
        out_status_reg <= out_status_next;
        out_poly_reg   <= out_poly_next;
        out_point_reg  <= out_point_next;
        out_row_reg    <= out_row_next;
        rd_valid_reg   <= rd_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pipe_valid_reg)
        begin
            bitmap_mem[pipe_addr_reg] <= wr_data;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    `OPP_ASSERT_NEXT(a_write_follows_walk, clk, rst_n, state_reg != ST_WALK,
        !pipe_valid_reg, "Bitmap write without a preceding walk step")
    `OPP_ASSERT_NEXT(a_error_sticky, clk, rst_n, err_reg, err_reg,
        "Latched segment error was cleared")
    `OPP_ASSERT_NEXT(a_walk_continues, clk, rst_n,
        (state_reg == ST_WALK) && (remain_reg != '0), state_reg == ST_WALK,
        "Walk left before the last row")
    `OPP_ASSERT_NEXT(a_latched_draw_no_walk, clk, rst_n,
        accept && (op == opp_pkg::OP_DRAW) && err_reg, state_reg == ST_RESP,
        "Draw walked although an error is latched")
    `OPP_ASSERT_NOW(a_flush_writes, clk, rst_n, state_reg == ST_FLUSH, pipe_valid_reg,
        "Last row of a walk was not written")

endmodule

@@ tb/tb_octilinear_polyline_plotter.sv @@
// Self-checking testbench for the octilinear polyline plotter, with its own bitmap predictor.
`timescale 1ns / 1ps

module tb_octilinear_polyline_plotter;

    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 180;
    localparam int WILD_ITEMS   = 100;
    localparam int HOLD_CYCLES  = 400;
    localparam int END_TAIL     = 80;
    localparam int REPICK_EVERY = 40;

    typedef struct packed {
        logic [1:0]                 status;
        logic [opp_pkg::CNT_W-1:0]  pline;
        logic [opp_pkg::CNT_W-1:0]  point;
        logic [opp_pkg::ROW_W-1:0]  row;
    } answer_t;

    typedef enum logic {DO_ITEM, DO_WRITE} step_kind_t;

    typedef struct packed {
        step_kind_t                   kind;
        logic                         reg_sel;
        logic [opp_pkg::CFG_W-1:0]    value;
        logic [1:0]                   op;
        logic [opp_pkg::COORD_W-1:0]  x;
        logic [opp_pkg::COORD_W-1:0]  y;
        logic                         typed;
        answer_t                      ans;
    } plot_step_t;

    localparam answer_t NO_ANSWER   = '0;
    localparam answer_t AFTER_RESET = '{opp_pkg::STATUS_OK, 16'd0, 16'd2, 64'd0};
    localparam answer_t FIRST_MOVE  = '{opp_pkg::STATUS_OK, 16'd1, 16'd1, 64'd0};

    localparam plot_step_t OPENING_STEPS [27] = '{
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd0, 1'b1, AFTER_RESET},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_NOP, 6'd63, 6'd63, 1'b1, AFTER_RESET},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd5, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd63, 6'd63, 1'b1, FIRST_MOVE},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd63, 6'd63, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd63, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd63, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd63, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd63, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd63, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd63, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd63, 6'd32, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_ROWS, 7'd1, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_COLS, 7'd1, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd1, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd1, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd0, 6'd1, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_COLS, 7'd127, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_ROWS, 7'd64, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER}
    };

    // The latched error is only cleared by reset, so these steps come after all phases; only the wild items follow.
    localparam plot_step_t CLOSING_STEPS [11] = '{
        '{DO_WRITE, opp_pkg::REG_GRID_ROWS, 7'd64, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_COLS, 7'd64, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd1, 6'd2, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_MOVE, 6'd5, 6'd5, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd10, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_WRITE, opp_pkg::REG_GRID_ROWS, 7'd2, opp_pkg::OP_NOP, 6'd0, 6'd0, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_READ, 6'd0, 6'd2, 1'b0, NO_ANSWER},
        '{DO_ITEM, opp_pkg::REG_GRID_ROWS, 7'd0, opp_pkg::OP_DRAW, 6'd63, 6'd63, 1'b0, NO_ANSWER}
    };

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [opp_pkg::PADDR_W-1:0]  paddr;
    logic [opp_pkg::PDATA_W-1:0]  pwdata;
    logic [opp_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;
    logic                         in_valid;
    logic                         in_ready;
    logic [1:0]                   op;
    logic [opp_pkg::COORD_W-1:0]  coord_x;
    logic [opp_pkg::COORD_W-1:0]  coord_y;
    logic                         out_valid;
    logic                         out_ready;
    logic [1:0]                   status;
    logic [opp_pkg::CNT_W-1:0]    polyline_number;
    logic [opp_pkg::CNT_W-1:0]    point_number;
    logic [opp_pkg::ROW_W-1:0]    row_bits;

    logic [opp_pkg::ROW_W-1:0]    plot_bitmap [opp_pkg::MAX_ROWS] = '{default: '0};
    logic [opp_pkg::COORD_W-1:0]  pen_col = '0;
    logic [opp_pkg::COORD_W-1:0]  pen_row = '0;
    logic [opp_pkg::CNT_W-1:0]    polyline_cnt = '0;
    logic [opp_pkg::CNT_W-1:0]    point_cnt = opp_pkg::POINT_FIRST_SEG;
    bit                           fault_latched = 1'b0;
    logic [opp_pkg::CFG_W-1:0]    grid_rows_reg = 7'd64;
    logic [opp_pkg::CFG_W-1:0]    grid_cols_reg = 7'd64;

    answer_t expected_answers [$];
    answer_t oldest_answer;
    int      mismatch_count = 0;
    int      offered_count = 0;
    int      taken_count = 0;
    bit      steady_send = 1'b0;
    bit      steady_take = 1'b0;
    bit      hold_outputs = 1'b0;

    octilinear_polyline_plotter dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int dim_in_use(input logic [opp_pkg::CFG_W-1:0] g, input int lim);
        if (g == '0)
        begin
            return 1;
        end
        return (int'(g) > lim) ? lim : int'(g);
    endfunction

    function automatic logic [opp_pkg::CNT_W-1:0] count_up(input logic [opp_pkg::CNT_W-1:0] v);
        return (v == '1) ? v : v + 16'd1;
    endfunction

    function automatic logic [opp_pkg::CFG_W-1:0] grid_choice();
        case ($urandom_range(0, 5))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd127;
            3: return 7'd64;
            default: return 7'($urandom_range(2, 64));
        endcase
    endfunction

    task automatic predict_answer(input logic [1:0] o, input logic [opp_pkg::COORD_W-1:0] x,
                                  input logic [opp_pkg::COORD_W-1:0] y, output answer_t a);
        int rows;
        int cols;
        int dx;
        int dy;
        int sx;
        int sy;
        int len;
        rows = dim_in_use(grid_rows_reg, opp_pkg::MAX_ROWS);
        cols = dim_in_use(grid_cols_reg, opp_pkg::MAX_COLS);
        a = '0;
        a.pline = polyline_cnt;
        a.point = point_cnt;
        a.status = fault_latched ? opp_pkg::STATUS_NOT_OCT : opp_pkg::STATUS_OK;
        if (o == opp_pkg::OP_READ)
        begin
            if (int'(y) >= rows)
            begin
                a.status = opp_pkg::STATUS_OUTSIDE;
            end
            else
            begin
                a.row = plot_bitmap[y]
                        & ((cols >= opp_pkg::ROW_W) ? '1 : ((64'd1 << cols) - 64'd1));
            end
        end
        else if (o == opp_pkg::OP_MOVE && !fault_latched)
        begin
            if (int'(x) >= cols || int'(y) >= rows)
            begin
                a.status = opp_pkg::STATUS_OUTSIDE;
            end
            else
            begin
                polyline_cnt = count_up(polyline_cnt);
                point_cnt = opp_pkg::POINT_FIRST_SEG;
                pen_col = x;
                pen_row = y;
                a.pline = polyline_cnt;
                a.point = opp_pkg::POINT_FIRST;
            end
        end
        else if (o == opp_pkg::OP_DRAW && !fault_latched)
        begin
            dx = int'(x) - int'(pen_col);
            dy = int'(y) - int'(pen_row);
            sx = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
            sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
            len = (dx * sx > dy * sy) ? dx * sx : dy * sy;
            if (int'(x) >= cols || int'(y) >= rows || int'(pen_col) >= cols
                || int'(pen_row) >= rows)
            begin
                a.status = opp_pkg::STATUS_OUTSIDE;
            end
            else if (dx != 0 && dy != 0 && dx * sx != dy * sy)
            begin
                fault_latched = 1'b1;
                a.status = opp_pkg::STATUS_NOT_OCT;
            end
            else
            begin
                for (int k = 0; k <= len; k++)
                begin
                    plot_bitmap[int'(pen_row) + sy * k][int'(pen_col) + sx * k] = 1'b1;
                end
                pen_col = x;
                pen_row = y;
                point_cnt = count_up(point_cnt);
            end
        end
    endtask

    task automatic send_item(input logic [1:0] o, input logic [opp_pkg::COORD_W-1:0] x,
                             input logic [opp_pkg::COORD_W-1:0] y, input logic typed,
                             input answer_t typed_ans);
        int gap;
        answer_t a;
        offered_count++;
        if (offered_count % REPICK_EVERY == 0)
        begin
            steady_send = ($urandom_range(0, 3) == 0);
        end
        gap = steady_send ? 0 : int'($urandom_range(0, 13));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        coord_x <= x;
        coord_y <= y;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_answer(o, x, y, a);
        expected_answers.push_back(typed ? typed_ans : a);
        @(negedge clk);
    endtask

    task automatic wait_idle(input int tail);
        in_valid <= 1'b0;
        while (expected_answers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (tail) @(negedge clk);
    endtask

    task automatic write_grid(input logic sel, input logic [opp_pkg::CFG_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= opp_pkg::PADDR_W'(sel) << 2;
        pwdata <= opp_pkg::PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == opp_pkg::REG_GRID_ROWS)
        begin
            grid_rows_reg = value;
        end
        else
        begin
            grid_cols_reg = value;
        end
        @(negedge clk);
    endtask

    task automatic apply_step(input plot_step_t s);
        if (s.kind == DO_WRITE)
        begin
            wait_idle(2);
            write_grid(s.reg_sel, s.value);
        end
        else
        begin
            send_item(s.op, s.x, s.y, s.typed, s.ans);
        end
    endtask

    task automatic pick_item(input bit wild, output logic [1:0] o,
                             output logic [opp_pkg::COORD_W-1:0] x,
                             output logic [opp_pkg::COORD_W-1:0] y);
        int rows;
        int cols;
        int roll;
        int sx;
        int sy;
        int reach;
        int k;
        int dx;
        int dy;
        rows = dim_in_use(grid_rows_reg, opp_pkg::MAX_ROWS);
        cols = dim_in_use(grid_cols_reg, opp_pkg::MAX_COLS);
        roll = int'($urandom_range(0, 99));
        o = 2'($urandom_range(0, 3));
        x = 6'($urandom_range(0, 63));
        y = 6'($urandom_range(0, 63));
        if (wild || roll >= 90)
        begin
            dx = int'(x) - int'(pen_col);
            dy = int'(y) - int'(pen_row);
            if (!wild && o == opp_pkg::OP_DRAW && dx != 0 && dy != 0 && dx != dy && dx != -dy)
            begin
                o = opp_pkg::OP_READ;
            end
        end
        else if (roll < 45)
        begin
            sx = int'($urandom_range(0, 2)) - 1;
            sy = int'($urandom_range(0, 2)) - 1;
            reach = opp_pkg::MAX_COLS - 1;
            if (sx > 0 && cols - 1 - int'(pen_col) < reach)
            begin
                reach = cols - 1 - int'(pen_col);
            end
            if (sx < 0 && int'(pen_col) < reach)
            begin
                reach = int'(pen_col);
            end
            if (sy > 0 && rows - 1 - int'(pen_row) < reach)
            begin
                reach = rows - 1 - int'(pen_row);
            end
            if (sy < 0 && int'(pen_row) < reach)
            begin
                reach = int'(pen_row);
            end
            if (reach < 0)
            begin
                reach = 0;
            end
            k = int'($urandom_range(0, reach));
            o = opp_pkg::OP_DRAW;
            x = 6'(int'(pen_col) + sx * k);
            y = 6'(int'(pen_row) + sy * k);
        end
        else if (roll < 65)
        begin
            o = opp_pkg::OP_MOVE;
            x = 6'($urandom_range(0, cols - 1));
            y = 6'($urandom_range(0, rows - 1));
        end
        else if (roll < 85)
        begin
            o = opp_pkg::OP_READ;
            if (roll % 8 != 0)
            begin
                y = 6'($urandom_range(0, rows - 1));
            end
        end
        else
        begin
            o = opp_pkg::OP_NOP;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, got status %0d",
                         $time, status);
            end
            else
            begin
                oldest_answer = expected_answers.pop_front();
                if (oldest_answer != {status, polyline_number, point_number, row_bits})
                begin
                    mismatch_count++;
                    if (oldest_answer.status != status)
                    begin
                        $display("%0t: status expected %0d, got %0d",
                                 $time, oldest_answer.status, status);
                    end
                    if (oldest_answer.pline != polyline_number)
                    begin
                        $display("%0t: polyline_number expected %0d, got %0d",
                                 $time, oldest_answer.pline, polyline_number);
                    end
                    if (oldest_answer.point != point_number)
                    begin
                        $display("%0t: point_number expected %0d, got %0d",
                                 $time, oldest_answer.point, point_number);
                    end
                    if (oldest_answer.row != row_bits)
                    begin
                        $display("%0t: row_bits expected %h, got %h",
                                 $time, oldest_answer.row, row_bits);
                    end
                end
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            int pause;
            if (hold_outputs)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_outputs = 1'b0;
            end
            taken_count++;
            if (taken_count % REPICK_EVERY == 0)
            begin
                steady_take = ($urandom_range(0, 3) == 0);
            end
            pause = steady_take ? 0 : int'($urandom_range(0, 13));
            if (pause > 0)
            begin
                out_ready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        logic [1:0]                   o;
        logic [opp_pkg::COORD_W-1:0]  x;
        logic [opp_pkg::COORD_W-1:0]  y;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = opp_pkg::OP_NOP;
        coord_x = '0;
        coord_y = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(OPENING_STEPS); i++)
        begin
            apply_step(OPENING_STEPS[i]);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                wait_idle(2);
                write_grid(opp_pkg::REG_GRID_ROWS, grid_choice());
                write_grid(opp_pkg::REG_GRID_COLS, grid_choice());
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 1 && i == 20)
                begin
                    hold_outputs = 1'b1;
                end
                pick_item(1'b0, o, x, y);
                send_item(o, x, y, 1'b0, NO_ANSWER);
            end
        end

        for (int i = 0; i < $size(CLOSING_STEPS); i++)
        begin
            apply_step(CLOSING_STEPS[i]);
        end
        for (int i = 0; i < WILD_ITEMS; i++)
        begin
            pick_item(1'b1, o, x, y);
            send_item(o, x, y, 1'b0, NO_ANSWER);
        end

        wait_idle(END_TAIL);
        if (mismatch_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/opp_pkg.sv
sv/octilinear_polyline_plotter.sv
tb/tb_octilinear_polyline_plotter.sv
